### src/sqoe_pkg.sv
// Shared types and codes for the stack/queue opcode engine.
package sqoe_pkg;

	localparam int VALUE_W = 32;
	localparam int LINE_W  = 24;

	typedef enum logic [2:0] {
		OP_PUSH      = 3'd0,
		OP_PRINT_ALL = 3'd1,
		OP_PRINT_TOP = 3'd2,
		OP_POP       = 3'd3,
		OP_SWAP      = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_DATA       = 3'd1,
		STS_BAD_ARG    = 3'd2,
		STS_PEEK_EMPTY = 3'd3,
		STS_POP_EMPTY  = 3'd4,
		STS_SWAP_SHORT = 3'd5,
		STS_FULL       = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_SWAP_B,
		S_SWAP_W1,
		S_SWAP_W2
	} state_t;

	typedef struct packed {
		logic [2:0]                mode;
		logic signed [VALUE_W-1:0] push_value;
		logic                      value_valid;
		logic [LINE_W-1:0]         script_line;
	} in_item_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] data_value;
		logic                      last;
		logic [LINE_W-1:0]         error_line;
	} out_item_t;

endpackage

### src/sqoe_store.sv
// Element store: one write port and one enabled read port with registered read data.
module sqoe_store import sqoe_pkg::*; #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [VALUE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// The read data holds its value until the next enabled read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/stack_queue_opcode_engine.sv
// Top level of the stack/queue opcode engine: control sequencer around the element store.
//
// The block keeps up to DEPTH signed 32-bit elements in a circular store and runs one
// opcode per input transaction: push, print all, print top, pop or swap. The input
// channel (in_valid, in_stall, in_data) and the result channel (out_valid, out_stall,
// out_data) move one transaction at a rising edge where valid is high and stall is low.
// The one-bit configuration register queue_mode is written over cfg_valid / cfg_ready /
// cfg_data; cfg_ready is always high, and writes are meant to happen while the block idles.
//
// Sequence per input transaction after its acceptance: push, pop, every error, print all on
// an empty store and unused opcodes emit their result from S_DECODE; print top reads the
// store in S_DECODE and emits from S_WALK; swap runs S_DECODE, S_SWAP_B, S_SWAP_W1 and
// S_SWAP_W2, since the single read port and single write port of the store serve the two
// entries one after the other; print all emits N results for N elements from S_WALK, one per
// cycle while the receiver does not stall, paced by the one store read per cycle.
//
// A registered output stage holds each result. A stall from the receiver freezes it and
// the sequencer waits, so nothing is lost. A new input transaction is taken as soon as the
// sequencer returns to idle, even while the last result still waits in the output stage.
// Reset empties the store logically (count and top pointer go to zero), clears queue_mode
// and drops any pending result; the store contents themselves are not cleared.
module stack_queue_opcode_engine import sqoe_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// Slot of the element at a given offset below the top, wrapping at DEPTH.
	// Both inputs stay below DEPTH, so a single conditional subtract suffices.
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
	                                             input logic [PTR_W-1:0] offset);
		logic [PTR_W:0] sum;
		sum = {1'b0, base} + {1'b0, offset};
		if (sum >= DEPTH_P) begin
			sum = sum - DEPTH_P;
		end
		return sum[PTR_W-1:0];
	endfunction

	state_t             state_q, state_d;
	in_item_t           item_q;
	logic               queue_mode_q;
	logic [PTR_W-1:0]   top_q, top_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [PTR_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   walk_len_q, walk_len_d;
	logic [VALUE_W-1:0] tmp_q;
	logic               tmp_load;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic               emit;
	out_item_t          emit_item;
	logic               out_free;
	logic [CNT_W-1:0]   idx_inc;
	logic               walk_last;

	logic               rd_en;
	logic [PTR_W-1:0]   rd_addr;
	logic [VALUE_W-1:0] rd_data;
	logic               wr_en;
	logic [PTR_W-1:0]   wr_addr;
	logic [VALUE_W-1:0] wr_data;

	sqoe_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (PTR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The output stage can take a new result when it is empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign idx_inc   = CNT_W'({1'b0, idx_q}) + CNT_W'(1);
	assign walk_last = (idx_inc == walk_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			queue_mode_q <= 1'b0;
			top_q        <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			walk_len_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			top_q      <= top_d;
			count_q    <= count_d;
			idx_q      <= idx_d;
			walk_len_q <= walk_len_d;
			if (cfg_valid && cfg_ready) begin
				queue_mode_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_data;
		end
		if (tmp_load) begin
			tmp_q <= rd_data;
		end
		if (emit) begin
			out_data_q <= emit_item;
		end
	end

	always_comb begin
		state_d    = state_q;
		top_d      = top_q;
		count_d    = count_q;
		idx_d      = idx_q;
		walk_len_d = walk_len_q;
		tmp_load   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = top_q;
		wr_en      = 1'b0;
		wr_addr    = top_q;
		wr_data    = item_q.push_value;
		emit       = 1'b0;

		emit_item.status     = STS_OK;
		emit_item.data_value = '0;
		emit_item.last       = 1'b1;
		emit_item.error_line = item_q.script_line;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end

			S_DECODE: begin
				if (out_free) begin
					state_d = S_IDLE;
					emit    = 1'b1;
					unique case (item_q.mode)
						OP_PUSH: begin
							if (!item_q.value_valid) begin
								emit_item.status = STS_BAD_ARG;
							end else if (count_q == DEPTH_C) begin
								emit_item.status = STS_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CNT_W'(1);
								if (queue_mode_q) begin
									// Queue mode appends below the current bottom element.
									wr_addr = slot_of(top_q, count_q[PTR_W-1:0]);
								end else begin
									// Stack mode moves the top up by one slot, wrapping.
									wr_addr = (top_q == '0) ? PTR_W'(DEPTH - 1)
									                        : top_q - PTR_W'(1);
									top_d   = wr_addr;
								end
							end
						end
						OP_PRINT_ALL, OP_PRINT_TOP: begin
							if (count_q == '0) begin
								if (item_q.mode == OP_PRINT_TOP) begin
									emit_item.status = STS_PEEK_EMPTY;
								end
							end else begin
								// Start the walk: read the top now, results follow.
								emit       = 1'b0;
								rd_en      = 1'b1;
								rd_addr    = top_q;
								idx_d      = '0;
								walk_len_d = (item_q.mode == OP_PRINT_TOP) ? CNT_W'(1)
								                                           : count_q;
								state_d    = S_WALK;
							end
						end
						OP_POP: begin
							if (count_q == '0) begin
								emit_item.status = STS_POP_EMPTY;
							end else begin
								top_d   = slot_of(top_q, PTR_W'(1));
								count_d = count_q - CNT_W'(1);
							end
						end
						OP_SWAP: begin
							if (count_q < CNT_W'(2)) begin
								emit_item.status = STS_SWAP_SHORT;
							end else begin
								emit    = 1'b0;
								rd_en   = 1'b1;
								rd_addr = top_q;
								state_d = S_SWAP_B;
							end
						end
						default: begin
							// Unused opcodes only acknowledge.
						end
					endcase
				end
			end

			S_WALK: begin
				emit_item.status     = STS_DATA;
				emit_item.data_value = rd_data;
				emit_item.last       = walk_last;
				if (out_free) begin
					emit = 1'b1;
					if (walk_last) begin
						state_d = S_IDLE;
					end else begin
						// Fetch the next element while this one leaves.
						idx_d   = idx_q + PTR_W'(1);
						rd_en   = 1'b1;
						rd_addr = slot_of(top_q, idx_q + PTR_W'(1));
					end
				end
			end

			S_SWAP_B: begin
				tmp_load = 1'b1;
				rd_en    = 1'b1;
				rd_addr  = slot_of(top_q, PTR_W'(1));
				state_d  = S_SWAP_W1;
			end

			S_SWAP_W1: begin
				wr_en   = 1'b1;
				wr_addr = top_q;
				wr_data = rd_data;
				state_d = S_SWAP_W2;
			end

			S_SWAP_W2: begin
				if (out_free) begin
					wr_en   = 1'b1;
					wr_addr = slot_of(top_q, PTR_W'(1));
					wr_data = tmp_q;
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### src/sqoe_checker.sv
// Port-level checker for the stack/queue opcode engine and its bind statement.
module sqoe_port_checker import sqoe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A held result must not change while the receiver stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed or vanished while stalled");

	// Only data results may continue an item; every other result closes it.
	a_nondata_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != STS_DATA) |-> out_data.last)
		else $error("non-data result without last");

	// Status and error results carry a zero value.
	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != STS_DATA) |-> (out_data.data_value == '0))
		else $error("non-data result with nonzero value");

	// The engine works on one transaction at a time, so it stalls right after taking one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again while busy");

endmodule

bind stack_queue_opcode_engine sqoe_port_checker u_sqoe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### verif/sqoe_checker.sv
// Result checker for the stack/queue opcode engine: mirrors the store, compares every result.
`timescale 1ns / 1ps

module sqoe_checker import sqoe_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic      cfg_data,
	output int        fail_count,
	output int        outstanding,
	output int        results_seen
);

	localparam int PTR_W = $clog2(DEPTH);

	logic signed [VALUE_W-1:0] slots [DEPTH];
	logic [PTR_W-1:0]          top_ptr;
	logic [PTR_W:0]            held;
	logic                      queue_order;
	out_item_t                 pending_results [$];

	initial begin
		fail_count   = 0;
		outstanding  = 0;
		results_seen = 0;
	end

	// Slot of the element at a given offset below the top, wrapping at DEPTH.
	function automatic logic [PTR_W-1:0] slot_at(int offset);
		return PTR_W'((int'(top_ptr) + offset) % DEPTH);
	endfunction

	function automatic void report_failure(string what);
		fail_count++;
		if (fail_count <= 10) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
	endfunction

	function automatic void add_result(status_t sts, logic signed [VALUE_W-1:0] value,
		logic is_last, logic [LINE_W-1:0] line);
		out_item_t r;
		r.status     = sts;
		r.data_value = value;
		r.last       = is_last;
		r.error_line = line;
		pending_results.push_back(r);
	endfunction

	// Applies one opcode to the mirrored store and queues the results it produces.
	function automatic void apply_opcode(in_item_t it);
		logic signed [VALUE_W-1:0] tmp;
		logic [PTR_W-1:0]          a;
		logic [PTR_W-1:0]          b;
		case (it.mode)
			OP_PUSH: begin
				if (!it.value_valid) begin
					add_result(STS_BAD_ARG, '0, 1'b1, it.script_line);
				end else if (held >= DEPTH) begin
					add_result(STS_FULL, '0, 1'b1, it.script_line);
				end else begin
					if (queue_order) begin
						slots[slot_at(int'(held))] = it.push_value;
					end else begin
						top_ptr = slot_at(DEPTH - 1);
						slots[top_ptr] = it.push_value;
					end
					held++;
					add_result(STS_OK, '0, 1'b1, it.script_line);
				end
			end
			OP_PRINT_ALL: begin
				if (held == 0) begin
					add_result(STS_OK, '0, 1'b1, it.script_line);
				end else begin
					for (int i = 0; i < held; i++) begin
						add_result(STS_DATA, slots[slot_at(i)], (i + 1 == held),
							it.script_line);
					end
				end
			end
			OP_PRINT_TOP: begin
				if (held == 0) begin
					add_result(STS_PEEK_EMPTY, '0, 1'b1, it.script_line);
				end else begin
					add_result(STS_DATA, slots[top_ptr], 1'b1, it.script_line);
				end
			end
			OP_POP: begin
				if (held == 0) begin
					add_result(STS_POP_EMPTY, '0, 1'b1, it.script_line);
				end else begin
					top_ptr = slot_at(1);
					held--;
					add_result(STS_OK, '0, 1'b1, it.script_line);
				end
			end
			OP_SWAP: begin
				if (held < 2) begin
					add_result(STS_SWAP_SHORT, '0, 1'b1, it.script_line);
				end else begin
					a = slot_at(0);
					b = slot_at(1);
					tmp = slots[a];
					slots[a] = slots[b];
					slots[b] = tmp;
					add_result(STS_OK, '0, 1'b1, it.script_line);
				end
			end
			default: begin
				add_result(STS_OK, '0, 1'b1, it.script_line);
			end
		endcase
	endfunction

	function automatic void compare_result(out_item_t got);
		out_item_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			report_failure($sformatf({"result %0d with nothing expected:",
				" status %0d data %0d last %0b line %0h"},
				results_seen, got.status, got.data_value, got.last, got.error_line));
			return;
		end
		want = pending_results.pop_front();
		if (got.status !== want.status || got.data_value !== want.data_value ||
			got.last !== want.last || got.error_line !== want.error_line) begin
			report_failure($sformatf({"result %0d: expected status %0d data %0d last %0b",
				" line %0h, got status %0d data %0d last %0b line %0h"}, results_seen,
				want.status, want.data_value, want.last, want.error_line,
				got.status, got.data_value, got.last, got.error_line));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_ptr     = '0;
			held        = '0;
			queue_order = 1'b0;
			pending_results.delete();
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				compare_result(out_data);
			end
			if (cfg_valid && cfg_ready) begin
				queue_order = cfg_data;
			end
			if (in_valid && !in_stall) begin
				apply_opcode(in_data);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

### verif/testbench.sv
// Top of the stack/queue opcode engine testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module testbench;
	import sqoe_pkg::*;

	localparam int DEPTH          = 64;
	// Cycles without any accepted transaction before the run is declared hung. The longest
	// legitimate quiet stretch is the receiver hold-off plus one long sender gap.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	// Settling time before a register write and after the last result at the end.
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RANDOM_CHUNK   = 17;

	// Opcodes the block does not define; it must still answer them with one ok result.
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_data;

	int fail_count;
	int outstanding;
	int results_seen;

	// Shared between the stimulus and the receiver. While calm is set, neither side idles.
	// The stimulus raises hold_req once; the receiver lowers it when it starts the hold-off.
	logic calm;
	logic hold_req;
	int   items_sent;
	int   idle_cycles;

	stack_queue_opcode_engine #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	sqoe_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle lengths: mostly none or a few cycles, now and then a long pause.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Push arguments lean on the extremes of the signed range, the rest is fully random.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return 32'sh7fff_ffff;
		end else if (r < 20) begin
			return 32'sh8000_0000;
		end else if (r < 25) begin
			return '0;
		end else if (r < 30) begin
			return -32'sd1;
		end
		return $urandom;
	endfunction

	// Any script line number over the full field.
	function automatic logic [LINE_W-1:0] pick_line();
		return LINE_W'($urandom_range(0, 24'hFF_FFFF));
	endfunction

	// Offers one input transaction and returns at the edge where it is accepted. Every call
	// starts at the falling edge right after the previous acceptance, so with no gap the
	// valid stays high and only the payload changes.
	task automatic send_op(logic [2:0] op, logic signed [VALUE_W-1:0] value, logic arg_ok,
		logic [LINE_W-1:0] line);
		int gap;
		gap = calm ? 0 : gap_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid            <= 1'b1;
		in_data.mode        <= op;
		in_data.push_value  <= value;
		in_data.value_valid <= arg_ok;
		in_data.script_line <= line;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// The block is only reconfigured while idle: the input is closed, every expected result
	// has arrived, and a few more cycles let the sequencer settle.
	task automatic set_queue_mode(logic qm);
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= qm;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random opcode. push_pct steers whether the store tends to fill or to drain.
	task automatic send_random(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct) begin
			send_op(OP_PUSH, pick_value(), $urandom_range(0, 9) != 0, pick_line());
		end else begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send_op(OP_PRINT_ALL, $urandom, $urandom_range(0, 1) != 0, pick_line());
			end else if (r < 32) begin
				send_op(OP_PRINT_TOP, $urandom, $urandom_range(0, 1) != 0, pick_line());
			end else if (r < 64) begin
				send_op(OP_POP, $urandom, $urandom_range(0, 1) != 0, pick_line());
			end else if (r < 94) begin
				send_op(OP_SWAP, $urandom, $urandom_range(0, 1) != 0, pick_line());
			end else begin
				send_op(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)), $urandom,
					$urandom_range(0, 1) != 0, pick_line());
			end
		end
	endtask

	// Receiver: random stalls between results, plus one long hold-off on request. Exactly
	// one assignment to out_stall happens at each falling edge.
	initial begin
		int stall_left;
		int hold_left;
		out_stall  = 1'b0;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				out_stall <= 1'b1;
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!calm) begin
					stall_left = gap_len();
				end
			end
		end
	end

	// Watchdog: any accepted transaction on any channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("[%0t] no transaction for %0d cycles, %0d results still expected",
						$realtime, idle_cycles, outstanding);
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		int leftover;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		calm        = 1'b0;
		hold_req    = 1'b0;
		items_sent  = 0;
		idle_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part in stack order. The empty store is probed first: every error
		// that needs no element, then print all on nothing, then a malformed push.
		set_queue_mode(1'b0);
		send_op(OP_POP, 32'sd0, 1'b1, 24'd1);
		send_op(OP_PRINT_TOP, 32'sd0, 1'b1, 24'd2);
		send_op(OP_SWAP, 32'sd0, 1'b1, 24'd3);
		send_op(OP_PRINT_ALL, 32'sd0, 1'b1, 24'd4);
		send_op(OP_PUSH, 32'sh7fff_ffff, 1'b0, 24'd5);
		// One element: swap is still short. Extreme values and line numbers go through.
		send_op(OP_PUSH, 32'sh7fff_ffff, 1'b1, 24'hFF_FFFF);
		send_op(OP_SWAP, 32'sd0, 1'b1, 24'd7);
		send_op(OP_PUSH, 32'sh8000_0000, 1'b1, 24'd0);
		send_op(OP_PRINT_TOP, 32'sd0, 1'b0, 24'd9);
		send_op(OP_SWAP, 32'sd0, 1'b0, 24'd10);
		send_op(OP_PRINT_ALL, 32'sd0, 1'b0, 24'd11);
		// Undefined opcodes leave the store alone.
		send_op(OP_SPARE_5, 32'sh5555_5555, 1'b1, 24'd12);
		send_op(OP_SPARE_6, 32'shAAAA_AAAA, 1'b0, 24'd13);
		send_op(OP_SPARE_7, -32'sd1, 1'b1, 24'd14);
		send_op(OP_POP, 32'sd0, 1'b1, 24'd15);
		send_op(OP_POP, 32'sd0, 1'b1, 24'd16);
		send_op(OP_POP, 32'sd0, 1'b1, 24'd17);

		// Queue order: pushes go to the bottom, so print all shows arrival order.
		set_queue_mode(1'b1);
		send_op(OP_PUSH, 32'sd1, 1'b1, 24'd20);
		send_op(OP_PUSH, 32'sd2, 1'b1, 24'd21);
		send_op(OP_PUSH, 32'sd3, 1'b1, 24'd22);
		send_op(OP_PRINT_ALL, 32'sd0, 1'b1, 24'd23);
		send_op(OP_POP, 32'sd0, 1'b1, 24'd24);
		send_op(OP_PRINT_ALL, 32'sd0, 1'b1, 24'd25);

		// Fill the store to capacity. The argument check comes before the fullness check,
		// so a malformed push on a full store reports the bad argument.
		while (items_sent < 23 + DEPTH - 2) begin
			send_op(OP_PUSH, $urandom, 1'b1, pick_line());
		end
		send_op(OP_PUSH, 32'sd7, 1'b1, 24'd100);
		send_op(OP_PUSH, 32'sd7, 1'b0, 24'd101);
		send_op(OP_PRINT_ALL, 32'sd0, 1'b1, 24'd102);
		send_op(OP_SWAP, 32'sd0, 1'b1, 24'd103);
		send_op(OP_PRINT_TOP, 32'sd0, 1'b1, 24'd104);
		repeat (3) send_op(OP_POP, 32'sd0, 1'b1, 24'd105);

		// Back to stack order on a nearly full store, topping it up until it refuses.
		set_queue_mode(1'b0);
		repeat (4) send_op(OP_PUSH, pick_value(), 1'b1, pick_line());
		send_op(OP_PRINT_ALL, 32'sd0, 1'b1, 24'd110);

		// Random part, draining first. Early on the receiver holds off for a long stretch
		// while the sender keeps offering, so the output stage fills and the input stalls.
		for (int i = 0; i < RANDOM_CHUNK; i++) begin
			if (i == 5) begin
				hold_req = 1'b1;
			end
			send_random(25);
		end

		// Queue order, push-heavy, so the full case recurs; a stretch runs with no idling.
		set_queue_mode(1'b1);
		for (int i = 0; i < RANDOM_CHUNK; i++) begin
			calm = (i >= 5 && i < 12);
			send_random(70);
		end
		calm = 1'b0;

		// Mixed traffic in a randomly chosen order.
		set_queue_mode($urandom_range(0, 1) != 0);
		for (int i = 0; i < RANDOM_CHUNK; i++) begin
			send_random(45);
		end
		send_op(OP_PRINT_ALL, 32'sd0, 1'b1, 24'hFF_FFFE);

		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		leftover = outstanding;
		if (leftover != 0) begin
			$display("%0d expected results never arrived", leftover);
		end
		$display("Sent %0d opcodes and checked %0d results across stack and queue order,",
			items_sent, results_seen);
		$display("including empty and full store errors and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (fail_count == 0 && leftover == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### files.f
src/sqoe_pkg.sv
src/sqoe_store.sv
src/stack_queue_opcode_engine.sv
src/sqoe_checker.sv
verif/sqoe_checker.sv
verif/testbench.sv
